// ----- hdl/ipv4lpf_pkg.sv -----
// ----------------------------------------------------------------------------
// ipv4lpf_pkg
// Shared types and constants of the IPv4 longest-prefix forwarder.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4lpf_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int ADDR_W = 32;
  localparam int LEN_W  = 6;
  localparam int TTL_W  = 8;
  localparam int CKS_W  = 16;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_FWD   = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    V_FORWARD     = 3'd0,
    V_LOCAL       = 3'd1,
    V_TTL_EXPIRED = 3'd2,
    V_NO_ROUTE    = 3'd3,
    V_ADDED       = 3'd4,
    V_TABLE_FULL  = 3'd5,
    V_CLEARED     = 3'd6
  } verdict_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] route_prefix;
    logic [LEN_W-1:0]  route_length;
    logic [ADDR_W-1:0] route_next_hop;
    logic [ADDR_W-1:0] packet_destination;
    logic [TTL_W-1:0]  packet_ttl;
    logic [CKS_W-1:0]  packet_checksum;
  } req_t;

  typedef struct packed {
    logic [2:0]        verdict;
    logic [ADDR_W-1:0] chosen_next_hop;
    logic [TTL_W-1:0]  updated_ttl;
    logic [CKS_W-1:0]  updated_checksum;
  } res_t;

  // route table entry
  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  length;
    logic [ADDR_W-1:0] hop;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic     load;
    logic     add;
    logic     clear;
    logic     scan_init;
    logic     scan_issue;
    logic     set_verdict;
    verdict_e verdict;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] opcode;
    logic       ttl_zero;
    logic       is_local;
    logic       table_full;
    logic       count_zero;
    logic       last_issue;
  } status_t;

endpackage

`default_nettype wire

// ----- hdl/ipv4lpf_ctrl.sv -----
// ----------------------------------------------------------------------------
// ipv4lpf_ctrl
// Sequencer: decodes the word, steps the route scan, strobes the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4lpf_ctrl
  import ipv4lpf_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o,
  output logic         busy_o,
  output logic         done_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_REPLY
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;
  logic   done_q, done_d;
  logic   accept;

  assign accept = start_i && !busy_q;

  always_comb begin
    cmd_o   = '0;
    cmd_o.verdict = V_NO_ROUTE;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = ST_REPLY;
        case (status_i.opcode)
          OP_ADD: begin
            cmd_o.set_verdict = 1'b1;
            cmd_o.verdict     = status_i.table_full ? V_TABLE_FULL : V_ADDED;
            cmd_o.add         = !status_i.table_full;
          end
          OP_CLEAR: begin
            cmd_o.set_verdict = 1'b1;
            cmd_o.verdict     = V_CLEARED;
            cmd_o.clear       = 1'b1;
          end
          OP_FWD: begin
            if (status_i.ttl_zero) begin
              cmd_o.set_verdict = 1'b1;
              cmd_o.verdict     = V_TTL_EXPIRED;
            end else if (status_i.is_local) begin
              cmd_o.set_verdict = 1'b1;
              cmd_o.verdict     = V_LOCAL;
            end else if (!status_i.count_zero) begin
              cmd_o.scan_init = 1'b1;
              state_d         = ST_SCAN;
            end
          end
          default: begin
            // unused opcode: hold the no-route verdict set on load
          end
        endcase
      end
      ST_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (status_i.last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last entry read is compared in this cycle
        state_d = ST_REPLY;
      end
      ST_REPLY: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_d = (state_d != ST_IDLE);
  assign done_d = (state_d == ST_REPLY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe longer than one cycle");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && !done_q)
    else $error("accepted word did not raise busy");

  a_done_in_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> busy_q && (state_q == ST_REPLY))
    else $error("result strobe outside reply");

  a_scan_forward : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (status_i.opcode == OP_FWD) && !status_i.count_zero)
    else $error("scan entered for a word that is not a forward");

endmodule

`default_nettype wire

// ----- hdl/ipv4lpf_dpath.sv -----
// ----------------------------------------------------------------------------
// ipv4lpf_dpath
// Route table memory, scan compare, local address register and result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4lpf_dpath
  import ipv4lpf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire req_t              req_i,
  input  wire cmd_t              cmd_i,
  input  wire logic              cfg_we_i,
  input  wire logic [ADDR_W-1:0] cfg_data_i,
  output status_t                status_o,
  output res_t                   res_o
);

  entry_t            mem [TABLE_DEPTH];
  entry_t            rd_q;
  entry_t            new_entry;
  req_t              req_q;
  logic [ADDR_W-1:0] local_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  idx_q;
  logic              rd_valid_q;
  logic [LEN_W-1:0]  best_q;
  logic [ADDR_W-1:0] hop_q;
  verdict_e          verdict_q;

  logic [ADDR_W-1:0] mask;
  logic              hit;
  logic              fwd;
  logic [CKS_W:0]    cks_s0;
  logic [CKS_W:0]    cks_s1;
  logic [CKS_W:0]    cks_s2;

  assign new_entry.prefix = req_q.route_prefix;
  assign new_entry.length = (req_q.route_length > MAX_LEN) ? MAX_LEN : req_q.route_length;
  assign new_entry.hop    = req_q.route_next_hop;

  // write one entry on add, read one entry per scan cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.add) begin
      mem[count_q[IDX_W-1:0]] <= new_entry;
    end
    rd_q <= mem[idx_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_q <= '0;
    end else if (cfg_we_i) begin
      local_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      idx_q      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        count_q <= '0;
      end else if (cmd_i.add) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.scan_init) begin
        idx_q <= '0;
      end else if (cmd_i.scan_issue) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      rd_valid_q <= cmd_i.scan_issue;
    end
  end

  // length 0 gives an empty mask, length 32 a full one
  assign mask = ~({ADDR_W{1'b1}} >> rd_q.length);
  assign hit  = rd_valid_q && (rd_q.length > best_q) &&
                (((rd_q.prefix ^ req_q.packet_destination) & mask) == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      best_q    <= '0;
      hop_q     <= '0;
      verdict_q <= V_NO_ROUTE;
    end else if (cmd_i.set_verdict) begin
      verdict_q <= cmd_i.verdict;
    end else if (hit) begin
      best_q    <= rd_q.length;
      hop_q     <= rd_q.hop;
      verdict_q <= V_FORWARD;
    end
  end

  assign status_o.opcode     = req_q.opcode;
  assign status_o.ttl_zero   = (req_q.packet_ttl == '0);
  assign status_o.is_local   = (req_q.packet_destination == local_q);
  assign status_o.table_full = (count_q == CNT_W'(TABLE_DEPTH));
  assign status_o.count_zero = (count_q == '0);
  assign status_o.last_issue = (idx_q == (count_q - CNT_W'(1)));

  // incremental checksum for a TTL drop of one: add 0xFEFF to ~hc, fold twice
  assign fwd    = (verdict_q == V_FORWARD);
  assign cks_s0 = {1'b0, ~req_q.packet_checksum} + (CKS_W+1)'(16'hFEFF);
  assign cks_s1 = {1'b0, cks_s0[CKS_W-1:0]} + (CKS_W+1)'(cks_s0[CKS_W]);
  assign cks_s2 = {1'b0, cks_s1[CKS_W-1:0]} + (CKS_W+1)'(cks_s1[CKS_W]);

  assign res_o.verdict          = verdict_q;
  assign res_o.chosen_next_hop  = fwd ? hop_q : '0;
  assign res_o.updated_ttl      = fwd ? (req_q.packet_ttl - TTL_W'(1)) : req_q.packet_ttl;
  assign res_o.updated_checksum = fwd ? ~cks_s2[CKS_W-1:0] : req_q.packet_checksum;

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_scan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_issue |-> idx_q < count_q)
    else $error("scan read beyond filled entries");

  a_hit_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit && !cmd_i.load && !cmd_i.set_verdict) |=> verdict_q == V_FORWARD && best_q != '0)
    else $error("match did not record a forward");

endmodule

`default_nettype wire

// ----- hdl/ipv4_longest_prefix_forwarder_core.sv -----
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_forwarder_core
// IPv4 route table with longest-prefix lookup and TTL/checksum update.
// ----------------------------------------------------------------------------
// Usage:
//   Command word on req_i is taken at a clock edge with start_i high and
//   busy_o low. Opcodes: add route, clear table, forward header.
//   One result word per command appears on res_o, marked by done_o for
//   exactly one cycle; the receiver must take it then, it cannot stall.
//   busy_o rises at the accepting edge and stays high up to and including
//   the done_o cycle, so the next command may follow in the cycle after.
//   Local address: written through cfg_valid_i/cfg_data_i, cfg_ready_o is
//   always high; write it only while busy_o is low.
//   Sequence: add, clear, unused opcode, TTL expired, local delivery and
//   empty table go from the check state straight to the reply; a forward
//   over N stored routes scans them, one memory read per route through a
//   single read port plus a registered compare, then drains the last
//   compare before the reply.
//   Reset clears the entry count and the local address; the route memory
//   holds no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_longest_prefix_forwarder_core
  import ipv4lpf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire req_t              req_i,
  output logic                   busy_o,
  output logic                   done_o,
  output res_t                   res_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [ADDR_W-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  ipv4lpf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  ipv4lpf_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .status_o   (status),
    .res_o      (res_o)
  );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IPv4 longest-prefix forwarder core. A short
// command table opens the run, then random phases of route adds, clears and
// header forwards follow, each under its own local address. The bench keeps
// its own copy of the route table and predicts every result word.
// ----------------------------------------------------------------------------

module tb_top;
  import ipv4lpf_pkg::*;

  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam int         IDLE_LIMIT    = 4000;
  localparam int         PHASES        = 7;
  localparam int         PHASE_ITEMS   = 250;
  localparam res_t       NO_WORD       = '0;

  typedef struct packed {
    req_t cmd;
    logic typed;
    res_t want;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              start_i     = 1'b0;
  req_t              req_i       = '0;
  logic              busy_o;
  logic              done_o;
  res_t              res_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [ADDR_W-1:0] cfg_data_i  = '0;

  // shadow route table and local address
  logic [ADDR_W-1:0] rt_prefix [TABLE_DEPTH];
  logic [LEN_W-1:0]  rt_len    [TABLE_DEPTH];
  logic [ADDR_W-1:0] rt_hop    [TABLE_DEPTH];
  int                rt_count;
  logic [ADDR_W-1:0] local_addr_q;

  res_t     pending_verdicts [$];
  dir_row_t dir_rows [$];
  int       mismatch_count = 0;
  int       idle_cycles    = 0;
  int       gap_ceiling;
  res_t     want_word;

  ipv4_longest_prefix_forwarder_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [ADDR_W-1:0] len_mask(logic [LEN_W-1:0] len);
    return (len == 0) ? '0 : (32'hFFFF_FFFF << (32 - int'(len)));
  endfunction

  // incremental checksum fix for a TTL drop of one (one's complement sum)
  function automatic logic [CKS_W-1:0] cks_ttl_drop(logic [CKS_W-1:0] c);
    logic [16:0] s;
    s = {1'b0, ~c} + 17'h0_FEFF;
    s = {1'b0, s[15:0]} + {16'h0, s[16]};
    s = {1'b0, s[15:0]} + {16'h0, s[16]};
    return ~s[15:0];
  endfunction

  // apply one command to the shadow table and return the word it yields
  function automatic res_t route_outcome(req_t r);
    res_t             o;
    logic [LEN_W-1:0] best_len;
    logic [ADDR_W-1:0] best_hop;
    o.verdict          = V_NO_ROUTE;
    o.chosen_next_hop  = '0;
    o.updated_ttl      = r.packet_ttl;
    o.updated_checksum = r.packet_checksum;
    best_len = '0;
    best_hop = '0;
    case (r.opcode)
      OP_ADD: begin
        if (rt_count >= TABLE_DEPTH) begin
          o.verdict = V_TABLE_FULL;
        end else begin
          rt_prefix[rt_count] = r.route_prefix;
          rt_len[rt_count]    = (r.route_length > MAX_LEN) ? MAX_LEN : r.route_length;
          rt_hop[rt_count]    = r.route_next_hop;
          rt_count++;
          o.verdict = V_ADDED;
        end
      end
      OP_CLEAR: begin
        rt_count  = 0;
        o.verdict = V_CLEARED;
      end
      OP_FWD: begin
        if (r.packet_ttl == 0) begin
          o.verdict = V_TTL_EXPIRED;
        end else if (r.packet_destination == local_addr_q) begin
          o.verdict = V_LOCAL;
        end else begin
          // strictly longer wins, so the earliest of equal lengths stays
          for (int i = 0; i < rt_count; i++) begin
            if (rt_len[i] > best_len &&
                ((rt_prefix[i] ^ r.packet_destination) & len_mask(rt_len[i])) == 0) begin
              best_len = rt_len[i];
              best_hop = rt_hop[i];
            end
          end
          if (best_len != 0) begin
            o.verdict          = V_FORWARD;
            o.chosen_next_hop  = best_hop;
            o.updated_ttl      = r.packet_ttl - 8'd1;
            o.updated_checksum = cks_ttl_drop(r.packet_checksum);
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic req_t cmd(logic [1:0] op, logic [31:0] pfx, logic [5:0] len,
                               logic [31:0] hop, logic [31:0] dst, logic [7:0] ttl,
                               logic [15:0] cks);
    req_t r;
    r.opcode             = op;
    r.route_prefix       = pfx;
    r.route_length       = len;
    r.route_next_hop     = hop;
    r.packet_destination = dst;
    r.packet_ttl         = ttl;
    r.packet_checksum    = cks;
    return r;
  endfunction

  function automatic res_t word(verdict_e v, logic [31:0] hop, logic [7:0] ttl,
                                logic [15:0] cks);
    res_t w;
    w.verdict          = v;
    w.chosen_next_hop  = hop;
    w.updated_ttl      = ttl;
    w.updated_checksum = cks;
    return w;
  endfunction

  // append one row to the directed table
  function automatic void add_row(input dir_row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // random command, mostly well-formed: destinations aimed at stored routes
  function automatic req_t random_cmd(int add_pct, int clear_pct);
    req_t             r;
    int unsigned      pick;
    int unsigned      j;
    logic [LEN_W-1:0] len;
    r = cmd(OP_FWD, $urandom, LEN_W'($urandom_range(0, 63)), $urandom, $urandom,
            TTL_W'($urandom_range(0, 255)), CKS_W'($urandom_range(0, 65535)));
    pick = $urandom_range(0, 99);
    if (pick < clear_pct) begin
      r.opcode = OP_CLEAR;
    end else if (pick < clear_pct + 2) begin
      r.opcode = OP_UNUSED;
    end else if (pick < clear_pct + 2 + add_pct) begin
      r.opcode = OP_ADD;
      case ($urandom_range(0, 9))
        0:       r.route_length = 6'd0;
        1:       r.route_length = LEN_W'($urandom_range(33, 63));
        2:       r.route_length = 6'd32;
        default: r.route_length = LEN_W'($urandom_range(1, 32));
      endcase
      if (rt_count > 0 && $urandom_range(0, 1) == 1) begin
        j = $urandom_range(0, rt_count - 1);
        r.route_prefix = rt_prefix[j];
        // keep some exact duplicates for the equal-length tie
        if ($urandom_range(0, 2) != 0)
          r.route_prefix ^= $urandom >> $urandom_range(0, 31);
      end
    end else begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        r.packet_destination = local_addr_q;
      end else if (pick <= 6 && rt_count > 0) begin
        j   = $urandom_range(0, rt_count - 1);
        len = rt_len[j];
        r.packet_destination = (rt_prefix[j] & len_mask(len)) | ($urandom & ~len_mask(len));
      end
      case ($urandom_range(0, 11))
        0:       r.packet_ttl = 8'd0;
        1:       r.packet_ttl = 8'd1;
        2:       r.packet_ttl = 8'hFF;
        default: ;
      endcase
      case ($urandom_range(0, 9))
        0:       r.packet_checksum = 16'h0000;
        1:       r.packet_checksum = 16'hFFFF;
        2:       r.packet_checksum = 16'hFEFF;
        default: ;
      endcase
    end
    return r;
  endfunction

  // after a random gap, hold start high until the core takes the word, then log its outcome
  task automatic send_cmd(input req_t r, input logic typed, input res_t typed_word);
    int unsigned gap;
    res_t        predicted;
    gap = $urandom_range(0, gap_ceiling);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    predicted = route_outcome(r);
    pending_verdicts.insert(pending_verdicts.size(), typed ? typed_word : predicted);
  endtask

  task automatic drain;
    start_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_local_addr(input logic [ADDR_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    local_addr_q = v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_verdicts.size() == 0) begin
        mismatch_count++;
        $display("%0t: result word with nothing expected, actual %h", $time, res_o);
      end else begin
        want_word = pending_verdicts.pop_front();
        check_field("verdict", 32'(want_word.verdict), 32'(res_o.verdict));
        check_field("chosen_next_hop", want_word.chosen_next_hop, res_o.chosen_next_hop);
        check_field("updated_ttl", 32'(want_word.updated_ttl), 32'(res_o.updated_ttl));
        check_field("updated_checksum", 32'(want_word.updated_checksum),
                    32'(res_o.updated_checksum));
      end
    end
  end

  // watchdog: cycles with no command, result or register write
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ipv4_longest_prefix_forwarder_core test failed");
        $finish;
      end
    end
  end

  initial begin
    int          add_pct;
    int          clear_pct;
    logic [31:0] addr;
    rt_count       = 0;
    local_addr_q   = '0;
    gap_ceiling    = 11;

    add_row({cmd(OP_FWD, 32'h0, 6'd0, 32'h0, 32'h0A00_0001, 8'd64, 16'h1234),
             1'b1, word(V_NO_ROUTE, 32'h0, 8'd64, 16'h1234)});
    add_row({cmd(OP_FWD, 32'h0, 6'd0, 32'h0, 32'h0, 8'd5, 16'hABCD),
             1'b1, word(V_LOCAL, 32'h0, 8'd5, 16'hABCD)});
    add_row({cmd(OP_FWD, 32'h0, 6'd0, 32'h0, 32'h0, 8'd0, 16'h0),
             1'b1, word(V_TTL_EXPIRED, 32'h0, 8'd0, 16'h0)});
    add_row({cmd(OP_UNUSED, '1, '1, '1, '1, '1, '1),
             1'b1, word(V_NO_ROUTE, 32'h0, 8'hFF, 16'hFFFF)});
    add_row({cmd(OP_ADD, 32'h0, 6'd0, 32'h1111_1111, 32'h0, 8'h33, 16'h4444),
             1'b1, word(V_ADDED, 32'h0, 8'h33, 16'h4444)});
    add_row({cmd(OP_FWD, 32'h0, 6'd0, 32'h0, 32'h0102_0304, 8'd10, 16'h5555),
             1'b0, NO_WORD});
    add_row({cmd(OP_ADD, 32'h0A00_0000, 6'd8, 32'hA000_0008, 32'h0, 8'd7, 16'h0),
             1'b1, word(V_ADDED, 32'h0, 8'd7, 16'h0)});
    add_row({cmd(OP_ADD, 32'h0A0B_0000, 6'd16, 32'hA00B_0016, 32'h0, 8'd0,
                 16'hFFFF), 1'b1, word(V_ADDED, 32'h0, 8'd0, 16'hFFFF)});
    add_row({cmd(OP_ADD, 32'h0A0B_0000, 6'd16, 32'hBEEF_0016, 32'h0, 8'd1, 16'h1),
             1'b0, NO_WORD});
    add_row({cmd(OP_ADD, 32'hC0A8_0101, 6'd63, 32'hC0A8_0001, 32'h0, 8'd2, 16'h2),
             1'b0, NO_WORD});
    add_row({cmd(OP_ADD, '1, 6'd32, '1, 32'h0, 8'd3, 16'h3), 1'b0, NO_WORD});
    add_row({cmd(OP_FWD, 32'h0, 6'd0, 32'h0, 32'h0A0B_0C0D, 8'hFF, 16'h0000),
             1'b0, NO_WORD});
    add_row({cmd(OP_FWD, 32'h0, 6'd0, 32'h0, 32'h0A7F_0001, 8'd1, 16'hFFFF),
             1'b0, NO_WORD});
    add_row({cmd(OP_FWD, 32'h0, 6'd0, 32'h0, 32'hC0A8_0101, 8'd2, 16'hFEFF),
             1'b0, NO_WORD});
    add_row({cmd(OP_FWD, 32'h0, 6'd0, 32'h0, '1, 8'h80, 16'h0001),
             1'b0, NO_WORD});
    add_row({cmd(OP_FWD, 32'h0, 6'd0, 32'h0, 32'hC0A8_0100, 8'h40, 16'h8000),
             1'b0, NO_WORD});
    add_row({cmd(OP_FWD, 32'h0, 6'd0, 32'h0, 32'h0A0B_0C0D, 8'd0, 16'h1357),
             1'b1, word(V_TTL_EXPIRED, 32'h0, 8'd0, 16'h1357)});
    add_row({cmd(OP_ADD, 32'h8000_0000, 6'd1, 32'h8000_0001, 32'h0, 8'd4, 16'h4),
             1'b0, NO_WORD});
    add_row({cmd(OP_FWD, 32'h0, 6'd0, 32'h0, 32'h8000_0001, 8'd3, 16'h2468),
             1'b0, NO_WORD});
    add_row({cmd(OP_UNUSED, 32'h0, 6'd0, 32'h0, 32'h0, 8'd0, 16'h0),
             1'b1, word(V_NO_ROUTE, 32'h0, 8'd0, 16'h0)});
    add_row({cmd(OP_CLEAR, 32'h0, 6'd0, 32'h0, 32'h0, 8'd9, 16'h9999),
             1'b1, word(V_CLEARED, 32'h0, 8'd9, 16'h9999)});
    add_row({cmd(OP_FWD, 32'h0, 6'd0, 32'h0, 32'h0A0B_0C0D, 8'd9, 16'h0001),
             1'b0, NO_WORD});
    add_row({cmd(OP_ADD, 32'h5555_5555, 6'd32, 32'hAAAA_AAAA, 32'h0, 8'd6,
                 16'h6666), 1'b1, word(V_ADDED, 32'h0, 8'd6, 16'h6666)});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k])
      send_cmd(dir_rows[k].cmd, dir_rows[k].typed, dir_rows[k].want);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      add_pct     = 35;
      clear_pct   = 3;
      gap_ceiling = 11;
      case (p)
        0: addr = '1;
        1: addr = $urandom;
        2: begin
          // fill the table and run into table_full
          addr      = '0;
          add_pct   = 70;
          clear_pct = 0;
        end
        3: begin
          addr        = 32'h0A0B_0C0D;
          gap_ceiling = 0;
        end
        4: addr = $urandom;
        5: begin
          addr      = 32'h8000_0000;
          add_pct   = 55;
          clear_pct = 1;
        end
        default: addr = 32'h0000_0001;
      endcase
      write_local_addr(addr);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_cmd(random_cmd(add_pct, clear_pct), 1'b0, NO_WORD);
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("ipv4_longest_prefix_forwarder_core test passed");
    else
      $display("ipv4_longest_prefix_forwarder_core test failed");
    $finish;
  end

endmodule
